FILE: rtl/stmp_pkg.sv
// stmp_pkg: shared constants and types for the segment tree max prefix core
// no dependencies
`default_nettype none
package stmp_pkg;
  localparam int LEAVES     = 1024;
  localparam int VALUE_BITS = 16;
  localparam int POS_BITS   = 10;
  localparam int IN_BITS    = 16;
  localparam int SUM_BITS   = 26;
  localparam int NODE_BITS  = POS_BITS + 1;
  localparam int NSUM_BITS  = 27;
  localparam int ENTRY_BITS = 2 * NSUM_BITS + POS_BITS;
  localparam int DEPTH      = 2 * LEAVES;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [NSUM_BITS-1:0] sum;
    logic signed [NSUM_BITS-1:0] best;
    logic [POS_BITS-1:0]         best_end;
  } node_t;

  // combine left node a with right node b, ties go to the right
  function automatic node_t combine(input node_t a, input node_t b);
    node_t r;
    logic signed [NSUM_BITS-1:0] via;
    via = a.sum + b.best;
    r.sum = a.sum + b.sum;
    if (a.best > via) begin
      r.best = a.best;
      r.best_end = a.best_end;
    end else begin
      r.best = via;
      r.best_end = b.best_end;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/stmp_if.sv
// stmp_in_if / stmp_out_if: valid-ready channels of the core
// depends on stmp_pkg
`default_nettype none
interface stmp_in_if import stmp_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  logic [POS_BITS-1:0] position;
  logic signed [IN_BITS-1:0] new_value;
  logic [POS_BITS-1:0] range_start;
  logic [POS_BITS-1:0] range_end;
  modport source(output valid, op, position, new_value, range_start, range_end, input ready);
  modport sink(input valid, op, position, new_value, range_start, range_end, output ready);
endinterface

interface stmp_out_if import stmp_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SUM_BITS-1:0] range_sum;
  logic signed [SUM_BITS-1:0] best_prefix_sum;
  logic [POS_BITS-1:0] best_prefix_end;
  logic range_ok;
  modport source(output valid, range_sum, best_prefix_sum, best_prefix_end, range_ok,
                 input ready);
  modport sink(input valid, range_sum, best_prefix_sum, best_prefix_end, range_ok,
               output ready);
endinterface
`default_nettype wire

FILE: rtl/stmp_ram.sv
// stmp_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module stmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/segment_tree_max_prefix_core.sv
// segment_tree_max_prefix_core: top level, sequencer around one node ram
// depends on stmp_pkg, stmp_if, stmp_ram
//
// channel | dir | fields
// in      | in  | op, position, new_value, range_start, range_end
// out     | out | range_sum, best_prefix_sum, best_prefix_end, range_ok
//
// after reset a clearing pass writes all 2*LEAVES nodes, in.ready low
// a set goes through write, wait and combine for each tree level below the root, then
// writes the root before the next transaction is taken
// a query block grows while aligned and inside the range, then is read, waited on and
// accumulated; at most 2*log2(LEAVES) blocks; a reversed range goes straight to done
// the single ram read port is why nodes are read one at a time
// a finished result sits in the out register; the next transaction is taken meanwhile,
// and a query that finishes while that register is full holds until out.ready
`default_nettype none
module segment_tree_max_prefix_core
  import stmp_pkg::*;
(
  input wire clk,
  input wire rst,
  stmp_in_if.sink    in,
  stmp_out_if.source out
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SREAD, S_SWAIT, S_SCOMB, S_QSIZE, S_QREAD, S_QWAIT, S_QACC, S_QDONE
  } state_t;

  state_t state;
  logic [NODE_BITS-1:0] node;     // current node / clear address
  node_t cur;                     // node value being pulled up / accumulator
  logic have;
  logic [NODE_BITS-1:0] qpos;     // query position, one wider than a leaf index
  logic [POS_BITS-1:0] qend;
  logic [NODE_BITS-1:0] qsize;
  logic [NODE_BITS-1:0] qnode;    // node covering qpos at block size qsize
  logic ok;

  logic we;
  logic [NODE_BITS-1:0] waddr, raddr;
  node_t wdata, rdata;

  stmp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // reset image of a node during the clearing pass
  node_t clr;
  logic [NODE_BITS-1:0] lvl_cnt;
  always_comb begin
    // count of leaves under node: LEAVES >> floor(log2(node))
    lvl_cnt = NODE_BITS'(LEAVES);
    for (int b = NODE_BITS - 1; b >= 0; b--) begin
      if (node[b] && ((node >> b) == NODE_BITS'(1))) begin
        lvl_cnt = NODE_BITS'(LEAVES) >> b;
      end
    end
    clr.sum  = -NSUM_BITS'(lvl_cnt);
    clr.best = -NSUM_BITS'(1);
    clr.best_end = POS_BITS'(node * lvl_cnt);
  end

  // sibling and parent combine for the set path
  node_t up;
  assign up = node[0] ? combine(rdata, cur) : combine(cur, rdata);

  // next query block size: grow while aligned and inside the range
  logic grow;
  assign grow = (qsize <= NODE_BITS'(LEAVES / 2)) &&
                ((qpos & ((qsize << 1) - 1'b1)) == '0) &&
                ({1'b0, qpos} + {1'b0, (qsize << 1)} - 1'b1 <= {1'b0, 1'b0, qend});

  always_comb begin
    we = 1'b0;
    waddr = node;
    wdata = cur;
    raddr = node ^ NODE_BITS'(1);
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        wdata = clr;
      end
      S_SREAD: begin
        we = 1'b1;
      end
      S_QREAD, S_QWAIT: raddr = qnode;
      default: ;
    endcase
  end

  assign in.ready = (state == S_IDLE);

  // result register loads once it is empty or being drained
  logic out_load;
  assign out_load = (state == S_QDONE) && (!out.valid || out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      node <= '0;
      out.valid <= 1'b0;
    end else begin
      if (out_load) out.valid <= 1'b1;
      else if (out.valid && out.ready) out.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          node <= node + 1'b1;
          if (node == NODE_BITS'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in.valid && in.ready) begin
            if (in.op == OP_SET) begin
              node <= NODE_BITS'(LEAVES) | NODE_BITS'(in.position);
              cur.sum  <= NSUM_BITS'(signed'(in.new_value[VALUE_BITS-1:0]));
              cur.best <= NSUM_BITS'(signed'(in.new_value[VALUE_BITS-1:0]));
              cur.best_end <= in.position;
              state <= S_SREAD;
            end else begin
              qpos <= {1'b0, in.range_start};
              qend <= in.range_end;
              qsize <= NODE_BITS'(1);
              qnode <= NODE_BITS'(LEAVES) | NODE_BITS'(in.range_start);
              have <= 1'b0;
              ok <= in.range_start <= in.range_end;
              state <= (in.range_start <= in.range_end) ? S_QSIZE : S_QDONE;
            end
          end
        end
        S_SREAD: begin      // write cur at node, sibling read issued
          state <= (node == NODE_BITS'(1)) ? S_IDLE : S_SWAIT;
        end
        S_SWAIT: state <= S_SCOMB;
        S_SCOMB: begin
          cur <= up;
          node <= node >> 1;
          state <= S_SREAD;
        end
        S_QSIZE: begin
          if (grow) begin
            qsize <= qsize << 1;
            qnode <= qnode >> 1;
          end else begin
            state <= S_QREAD;
          end
        end
        S_QREAD: state <= S_QWAIT;
        S_QWAIT: state <= S_QACC;
        S_QACC: begin
          cur <= have ? combine(cur, rdata) : rdata;
          have <= 1'b1;
          qpos <= qpos + qsize;
          qsize <= NODE_BITS'(1);
          qnode <= NODE_BITS'(LEAVES) | (qpos + qsize);
          state <= ({1'b0, qpos} + {1'b0, qsize} > {2'b0, qend}) ? S_QDONE : S_QSIZE;
        end
        S_QDONE: begin
          if (out_load) begin
            out.range_ok <= ok;
            out.range_sum <= ok ? SUM_BITS'(cur.sum) : '0;
            out.best_prefix_sum <= ok ? SUM_BITS'(cur.best) : '0;
            out.best_prefix_end <= ok ? cur.best_end : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: verif/segment_tree_max_prefix_core_tb.sv
// segment_tree_max_prefix_core_tb: self-checking bench for the segment tree max prefix core
// depends on stmp_pkg, stmp_if and the core; carries its own tree model for prediction
`default_nettype none
module segment_tree_max_prefix_core_tb;
  import stmp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected query answer
  typedef struct packed {
    logic signed [SUM_BITS-1:0] range_sum;
    logic signed [SUM_BITS-1:0] best_prefix_sum;
    logic [POS_BITS-1:0]        best_prefix_end;
    logic                       range_ok;
  } answer_t;

  // model node, wide enough that no sum ever wraps
  typedef struct {
    longint sum;
    longint best;
    int     best_end;
  } tree_node_t;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   fail_count = 0;

  stmp_in_if  in_ch ();
  stmp_out_if out_ch ();

  segment_tree_max_prefix_core u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  tree_node_t tree[DEPTH];
  answer_t    pending_answers[$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // global watchdog: clearing pass plus slow sets and long stalls, taken several times over
  localparam int CYCLE_LIMIT = 3000000;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // merge a left node with the node on its right; a tie picks the right side
  function automatic tree_node_t merge_nodes(input tree_node_t a, input tree_node_t b);
    tree_node_t r;
    longint via;
    via = a.sum + b.best;
    r.sum = a.sum + b.sum;
    if (a.best > via) begin
      r.best = a.best;
      r.best_end = a.best_end;
    end else begin
      r.best = via;
      r.best_end = b.best_end;
    end
    return r;
  endfunction

  // every leaf starts at -1
  task automatic clear_tree();
    for (int i = 0; i < LEAVES; i++) begin
      tree[LEAVES + i].sum = -1;
      tree[LEAVES + i].best = -1;
      tree[LEAVES + i].best_end = i;
    end
    for (int i = LEAVES - 1; i >= 1; i--) tree[i] = merge_nodes(tree[2*i], tree[2*i+1]);
  endtask

  // leaf write then walk up to the root
  task automatic write_leaf(input int pos, input logic [IN_BITS-1:0] raw);
    int node;
    longint val;
    val = longint'($signed(raw[VALUE_BITS-1:0]));
    node = LEAVES + pos;
    tree[node].sum = val;
    tree[node].best = val;
    tree[node].best_end = pos;
    for (node = node >> 1; node >= 1; node = node >> 1)
      tree[node] = merge_nodes(tree[2*node], tree[2*node+1]);
  endtask

  // range answer from the canonical decomposition, left to right
  function automatic answer_t range_answer(input int lo, input int hi);
    answer_t a;
    tree_node_t acc;
    bit have;
    int pos, size, node;
    a = '0;
    if (lo > hi || hi >= LEAVES) return a;
    have = 0;
    pos = lo;
    while (pos <= hi) begin
      size = 1;
      while (size * 2 <= LEAVES && (pos & (size * 2 - 1)) == 0 && pos + size * 2 - 1 <= hi)
        size = size * 2;
      node = (LEAVES + pos) / size;
      if (!have) acc = tree[node];
      else acc = merge_nodes(acc, tree[node]);
      have = 1;
      pos += size;
    end
    a.range_sum = acc.sum[SUM_BITS-1:0];
    a.best_prefix_sum = acc.best[SUM_BITS-1:0];
    a.best_prefix_end = acc.best_end[POS_BITS-1:0];
    a.range_ok = 1'b1;
    return a;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // drive one transaction and update the model once it is accepted
  // valid stays high after the accepting edge until the next call drops or reuses it
  task automatic send_item(input logic op, input logic [POS_BITS-1:0] pos,
                           input logic [IN_BITS-1:0] value,
                           input logic [POS_BITS-1:0] lo, input logic [POS_BITS-1:0] hi);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.position    <= pos;
    in_ch.new_value   <= value;
    in_ch.range_start <= lo;
    in_ch.range_end   <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // transaction taken at this edge
    if (op == OP_SET) write_leaf(int'(pos), value);
    else pending_answers = {pending_answers, range_answer(int'(lo), int'(hi))};
  endtask

  // result side: random stalls on ready, then compare each accepted result
  initial begin
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_answers.size() == 0) begin
          $error("result with no query waiting");
          fail_count++;
        end else begin
          answer_t e;
          e = pending_answers.pop_front();
          if (out_ch.range_sum !== e.range_sum) begin
            $error("range_sum expected %0d actual %0d", e.range_sum, out_ch.range_sum);
            fail_count++;
          end
          if (out_ch.best_prefix_sum !== e.best_prefix_sum) begin
            $error("best_prefix_sum expected %0d actual %0d", e.best_prefix_sum,
                   out_ch.best_prefix_sum);
            fail_count++;
          end
          if (out_ch.best_prefix_end !== e.best_prefix_end) begin
            $error("best_prefix_end expected %0d actual %0d", e.best_prefix_end,
                   out_ch.best_prefix_end);
            fail_count++;
          end
          if (out_ch.range_ok !== e.range_ok) begin
            $error("range_ok expected %0d actual %0d", e.range_ok, out_ch.range_ok);
            fail_count++;
          end
        end
      end
      // ready stays high over stretches, with short and rare long stalls
      if ($urandom_range(0, 99) < 70) out_ch.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 95) out_ch.ready <= 1'b0;
      else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 100)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic query(input int lo, input int hi);
    send_item(OP_QUERY, POS_BITS'($urandom), IN_BITS'($urandom),
              lo[POS_BITS-1:0], hi[POS_BITS-1:0]);
  endtask

  task automatic set_leaf(input int pos, input int value);
    send_item(OP_SET, pos[POS_BITS-1:0], value[IN_BITS-1:0],
              POS_BITS'($urandom), POS_BITS'($urandom));
  endtask

  // tree straight out of reset, all leaves -1: the best prefix ends at the first leaf
  task automatic test_reset_tree();
    query(0, LEAVES - 1);
    query(0, 0);
    query(5, 9);
    query(LEAVES - 1, LEAVES - 1);
  endtask

  // extreme values, reversed ranges and a tie
  task automatic test_directed_edges();
    set_leaf(0, 32767);
    set_leaf(LEAVES - 1, -32768);
    set_leaf(1, -32768);
    set_leaf(2, 32767);
    set_leaf(3, 0);
    query(0, LEAVES - 1);
    query(0, 3);
    query(1, 2);
    query(LEAVES - 1, LEAVES - 1);
    query(7, 6);
    query(LEAVES - 1, 0);
    // tie: later zero-sum end should win
    set_leaf(10, 5);
    set_leaf(11, -5);
    set_leaf(12, 5);
    query(10, 12);
    query(10, 11);
    set_leaf(4, 32767);
    query(3, 500);
  endtask

  // random mix, queries over short, long and bad ranges
  task automatic test_random_mix(input int count);
    int lo, hi, r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 3) == 0) set_leaf($urandom_range(0, 15), $urandom);
        else set_leaf($urandom_range(0, LEAVES - 1), $urandom);
      end else begin
        lo = $urandom_range(0, LEAVES - 1);
        r = $urandom_range(0, 9);
        if (r < 4) hi = lo + $urandom_range(0, 16);
        else if (r < 8) hi = $urandom_range(lo, LEAVES - 1);
        else hi = $urandom_range(0, LEAVES - 1);
        if (hi > LEAVES - 1) hi = LEAVES - 1;
        if ($urandom_range(0, 19) == 0) begin
          lo = 0;
          hi = LEAVES - 1;
        end
        query(lo, hi);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SET;
    in_ch.position = '0;
    in_ch.new_value = '0;
    in_ch.range_start = '0;
    in_ch.range_end = '0;
    clear_tree();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_tree();
    test_directed_edges();
    test_random_mix(1200);
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/stmp_pkg.sv
rtl/stmp_if.sv
rtl/stmp_ram.sv
rtl/segment_tree_max_prefix_core.sv
verif/segment_tree_max_prefix_core_tb.sv
